FILE: rtl/ptla_pkg.sv
`timescale 1ns / 1ps
// Package for the peer table: sizes, op and status codes, and the command
// and result records shared by the front, back and top level. No dependencies.
package ptla_pkg;

    localparam int ENTRIES     = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 32;
    localparam int QUEUE_DEPTH = 2;  // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_PRUNE  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SELF_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 1'd1;

    typedef enum logic [2:0] {
        ST_SELF      = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_NEW       = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_REMOVED   = 3'd6,
        ST_NONE_RM   = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [3:0]        entry_index;
        logic [ADDR_W-1:0] removed_address;
        logic [4:0]        active_count;
        logic              last;
    } res_t;

endpackage

FILE: rtl/ptla_front.sv
`timescale 1ns / 1ps
// Front of the peer table: accepts input beats, drops unused op codes and
// queues commands for the back end. Depends on ptla_pkg.
module ptla_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [47:0]        peer_address,
    input  logic [31:0]        now_ms,
    output logic               q_valid,
    input  logic               q_pop,
    output ptla_pkg::cmd_t     q_cmd
);

    ptla_pkg::cmd_t                    q_mem [ptla_pkg::QUEUE_DEPTH];
    logic [ptla_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ptla_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ptla_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              push;
    logic                              pop;

    assign in_ready = (cnt_reg != ptla_pkg::QCNT_W'(ptla_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready && (op != ptla_pkg::OP_NONE);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{op: op, addr: peer_address, now: now_ms};
        end
    end

endmodule

FILE: rtl/ptla_back.sv
`timescale 1ns / 1ps
// Back end of the peer table: holds the slots, scans them one per cycle for
// each command and drives the result register. Depends on ptla_pkg.
module ptla_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  ptla_pkg::cmd_t                  q_cmd,
    input  logic [ptla_pkg::ADDR_W-1:0]     self_address,
    input  logic [ptla_pkg::TIME_W-1:0]     timeout_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ptla_pkg::res_t                  res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DONE  = 4'b0100,
        S_PEMIT = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    ptla_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [ptla_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                           hit_reg, hit_next;
    logic [ptla_pkg::IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                           hit_zero_reg, hit_zero_next;
    logic                           free_reg, free_next;
    logic [ptla_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [ptla_pkg::ENTRIES-1:0]   stale_reg, stale_next;
    logic [ptla_pkg::ENTRIES-1:0]   valid_reg, valid_next;
    logic [ptla_pkg::CNT_W-1:0]     rm_total_reg, rm_total_next;
    logic [ptla_pkg::CNT_W-1:0]     rm_left_reg, rm_left_next;
    logic [ptla_pkg::CNT_W-1:0]     active_reg, active_next;
    logic                           out_valid_reg, out_valid_next;
    ptla_pkg::res_t                 res_reg, res_next;

    logic [ptla_pkg::ADDR_W-1:0]    addr_mem [ptla_pkg::ENTRIES];
    logic [ptla_pkg::TIME_W-1:0]    time_mem [ptla_pkg::ENTRIES];

    logic                           wr_time_en;
    logic                           wr_addr_en;
    logic [ptla_pkg::IDX_W-1:0]     wr_idx;

    logic                           cur_valid;
    logic [ptla_pkg::TIME_W-1:0]    cur_time;
    logic                           cur_match;
    logic                           cur_stale;
    logic                           last_idx;
    logic                           slot_free;
    logic [ptla_pkg::CNT_W-1:0]     final_cnt;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // An invalid slot reads as time zero, so a claimed slot always looks new.
    assign cur_valid = valid_reg[idx_reg];
    assign cur_time  = cur_valid ? time_mem[idx_reg] : '0;
    assign cur_match = cur_valid && (addr_mem[idx_reg] == cmd_reg.addr);
    assign cur_stale = cur_valid && ((cmd_reg.now - cur_time) > timeout_ms);
    assign last_idx  = (idx_reg == ptla_pkg::IDX_W'(ptla_pkg::ENTRIES - 1));
    assign final_cnt = active_reg - rm_total_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_zero_next  = hit_zero_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        stale_next     = stale_reg;
        valid_next     = valid_reg;
        rm_total_next  = rm_total_reg;
        rm_left_next   = rm_left_reg;
        active_next    = active_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        wr_time_en     = 1'b0;
        wr_addr_en     = 1'b0;
        wr_idx         = hit_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    rm_total_next = '0;
                    stale_next    = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (cur_match && !hit_reg)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = idx_reg;
                    hit_zero_next = (cur_time == '0);
                end
                if (!cur_valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (cmd_reg.op == ptla_pkg::OP_PRUNE)
                begin
                    stale_next[idx_reg] = cur_stale;
                    rm_total_next = rm_total_reg + ptla_pkg::CNT_W'(cur_stale);
                end
                if (last_idx)
                begin
                    idx_next     = '0;
                    rm_left_next = rm_total_next;
                    state_next   = (cmd_reg.op == ptla_pkg::OP_PRUNE) ? S_PEMIT : S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    res_next.entry_index     = '0;
                    res_next.removed_address = '0;
                    res_next.last            = 1'b1;
                    res_next.active_count    = 5'(active_reg);
                    state_next               = S_IDLE;
                    if (cmd_reg.op == ptla_pkg::OP_LOOKUP)
                    begin
                        if (hit_reg)
                        begin
                            res_next.status      = ptla_pkg::ST_FOUND;
                            res_next.entry_index = 4'(hit_idx_reg);
                        end
                        else
                        begin
                            res_next.status = ptla_pkg::ST_NOT_FOUND;
                        end
                    end
                    else if (cmd_reg.addr == self_address)
                    begin
                        res_next.status = ptla_pkg::ST_SELF;
                    end
                    else if (hit_reg)
                    begin
                        res_next.status      = hit_zero_reg ? ptla_pkg::ST_NEW
                                                            : ptla_pkg::ST_REFRESHED;
                        res_next.entry_index = 4'(hit_idx_reg);
                        wr_time_en           = 1'b1;
                    end
                    else if (free_reg)
                    begin
                        wr_idx                   = free_idx_reg;
                        wr_time_en               = 1'b1;
                        wr_addr_en               = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        active_next              = active_reg + 1'b1;
                        res_next.status          = ptla_pkg::ST_NEW;
                        res_next.entry_index     = 4'(free_idx_reg);
                        res_next.active_count    = 5'(active_reg + 1'b1);
                    end
                    else
                    begin
                        res_next.status = ptla_pkg::ST_FULL;
                    end
                end
            end

            S_PEMIT:
            begin
                if (rm_total_reg == '0)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        res_next       = '{status: ptla_pkg::ST_NONE_RM, entry_index: '0,
                                           removed_address: '0,
                                           active_count: 5'(active_reg), last: 1'b1};
                        state_next     = S_IDLE;
                    end
                end
                else if (stale_reg[idx_reg])
                begin
                    if (slot_free)
                    begin
                        out_valid_next      = 1'b1;
                        res_next            = '{status: ptla_pkg::ST_REMOVED,
                                                entry_index: 4'(idx_reg),
                                                removed_address: addr_mem[idx_reg],
                                                active_count: 5'(final_cnt),
                                                last: (rm_left_reg == 1'b1)};
                        valid_next[idx_reg] = 1'b0;
                        rm_left_next        = rm_left_reg - 1'b1;
                        idx_next            = idx_reg + 1'b1;
                        if (rm_left_reg == 1'b1)
                        begin
                            active_next = final_cnt;
                            state_next  = S_IDLE;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            stale_reg     <= '0;
            rm_total_reg  <= '0;
            rm_left_reg   <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            stale_reg     <= stale_next;
            rm_total_reg  <= rm_total_next;
            rm_left_reg   <= rm_left_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        hit_idx_reg   <= hit_idx_next;
        hit_zero_reg  <= hit_zero_next;
        free_idx_reg  <= free_idx_next;
        res_reg       <= res_next;
        if (wr_time_en)
        begin
            time_mem[wr_idx] <= cmd_reg.now;
        end
        if (wr_addr_en)
        begin
            addr_mem[wr_idx] <= cmd_reg.addr;
        end
    end

endmodule

FILE: rtl/peer_table_learn_and_age.sv
`timescale 1ns / 1ps
// Peer table with learning and aging: top level joining front queue, back end
// and configuration registers. Depends on ptla_pkg, ptla_front, ptla_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat carries op, peer_address and
//   now_ms. Op 0 learns or refreshes a peer, op 1 looks one up, op 2 prunes
//   slots whose wrapping age exceeds timeout_ms. Op 3 is taken and dropped.
//   Output channel (out_valid/out_ready): one beat per result; learn and
//   lookup give one, prune gives one per removed slot in slot order (or one
//   "none removed"). The last beat of an item has last set.
//   Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index 0
//   writes self_address, 1 writes timeout_ms from the low 32 bits of data.
//   Write it only while no item is in flight.
// Timing: the back end scans one slot per cycle. Learn and lookup give their
//   result once the scan of all ENTRIES slots ends; prune scans all slots,
//   then walks them again in an emit pass, one result per stale slot. A
//   two-deep command queue accepts new beats while the back end works, so
//   the front stalls only when it is full.
// Reset: all slots go invalid, self_address clears, timeout_ms is 30000.
// Stall: a result waits in the output register until taken; the back end
//   holds before its next result and the queue keeps filling.
module peer_table_learn_and_age (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           op,
    input  logic [47:0]                          peer_address,
    input  logic [31:0]                          now_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           status,
    output logic [3:0]                           entry_index,
    output logic [47:0]                          removed_address,
    output logic [4:0]                           active_count,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ptla_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [47:0]                          cfg_data
);

    logic [ptla_pkg::ADDR_W-1:0] self_address_reg;
    logic [ptla_pkg::TIME_W-1:0] timeout_ms_reg;
    logic                        q_valid;
    logic                        q_pop;
    ptla_pkg::cmd_t              q_cmd;
    ptla_pkg::res_t              res;

    // Config port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_address_reg <= '0;
            timeout_ms_reg   <= 32'd30000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptla_pkg::REG_SELF_ADDRESS: self_address_reg <= cfg_data;
                ptla_pkg::REG_TIMEOUT_MS:   timeout_ms_reg   <= cfg_data[31:0];
                default:                    ;
            endcase
        end
    end

    // Accept and queue commands.
    ptla_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .peer_address (peer_address),
        .now_ms       (now_ms),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd)
    );

    // Scan the table and emit results.
    ptla_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd),
        .self_address (self_address_reg),
        .timeout_ms   (timeout_ms_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res          (res)
    );

    assign status          = res.status;
    assign entry_index     = res.entry_index;
    assign removed_address = res.removed_address;
    assign active_count    = res.active_count;
    assign last            = res.last;

endmodule

FILE: rtl/ptla_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the peer table, bound to the top level.
// Depends on ptla_pkg and peer_table_learn_and_age.
module ptla_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [3:0]  entry_index,
    input logic [47:0] removed_address,
    input logic [4:0]  active_count,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(entry_index)
            && $stable(removed_address) && $stable(active_count) && $stable(last))
        else $error("stalled result beat changed");

    a_none_rm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ptla_pkg::ST_NONE_RM) |-> last && (entry_index == 4'd0))
        else $error("none-removed beat malformed");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ptla_pkg::ST_REMOVED) |-> last && (removed_address == 48'd0))
        else $error("single result beat malformed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_count <= 5'(ptla_pkg::ENTRIES)))
        else $error("active count above table size");

endmodule

bind peer_table_learn_and_age ptla_checker u_ptla_checker (.*);

FILE: dv/peer_table_learn_and_age_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the peer table: a directed table of beats, then
// random learn/lookup/prune traffic, checked against an in-bench table model.
// Depends on ptla_pkg and peer_table_learn_and_age.
module peer_table_learn_and_age_tb;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [47:0] removed_address;
        logic [4:0]  active_count;
        logic        last;
    } peer_res_t;

    typedef struct {
        logic [1:0]  op;
        logic [47:0] addr;
        logic [31:0] now;
        bit          typed;     // expected result given in the row
        logic [2:0]  st;
        logic [3:0]  idx;
        logic [4:0]  cnt;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = '0;
    logic [47:0] peer_address = '0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [47:0] removed_address;
    logic [4:0]  active_count;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [ptla_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;

    peer_table_learn_and_age dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the table and its registers.
    bit          slot_valid [ptla_pkg::ENTRIES];
    logic [47:0] slot_addr  [ptla_pkg::ENTRIES];
    logic [31:0] slot_seen  [ptla_pkg::ENTRIES];
    logic [47:0] own_addr = '0;
    logic [31:0] age_limit = 32'd30000;

    peer_res_t pending_results[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic [47:0] known_peers[$];

    function automatic logic [4:0] live_slots();
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < ptla_pkg::ENTRIES; i++)
            n += slot_valid[i];
        return n;
    endfunction

    function automatic int locate_peer(logic [47:0] a);
        for (int i = 0; i < ptla_pkg::ENTRIES; i++)
            if (slot_valid[i] && slot_addr[i] == a)
                return i;
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] s, int idx, logic [47:0] ra, logic l);
        peer_res_t r;
        r.status = s;
        r.entry_index = idx[3:0];
        r.removed_address = ra;
        r.active_count = live_slots();
        r.last = l;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow table by one command and queue its results.
    function automatic void apply_command(logic [1:0] o, logic [47:0] a, logic [31:0] t);
        int slot;
        int hits[$];
        logic [47:0] gone[$];
        if (o == ptla_pkg::OP_LEARN)
        begin
            if (a == own_addr)
            begin
                push_result(ptla_pkg::ST_SELF, 0, '0, 1'b1);
                return;
            end
            slot = locate_peer(a);
            if (slot < 0)
            begin
                for (int i = 0; i < ptla_pkg::ENTRIES; i++)
                    if (!slot_valid[i])
                    begin
                        slot = i;
                        break;
                    end
                if (slot < 0)
                begin
                    push_result(ptla_pkg::ST_FULL, 0, '0, 1'b1);
                    return;
                end
                slot_valid[slot] = 1'b1;
                slot_addr[slot] = a;
            end
            // a slot stamped at time zero still reads as new
            push_result((slot_seen[slot] == 0) ? ptla_pkg::ST_NEW : ptla_pkg::ST_REFRESHED,
                        slot, '0, 1'b1);
            slot_seen[slot] = t;
        end
        else if (o == ptla_pkg::OP_LOOKUP)
        begin
            slot = locate_peer(a);
            if (slot < 0)
                push_result(ptla_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
            else
                push_result(ptla_pkg::ST_FOUND, slot, '0, 1'b1);
        end
        else if (o == ptla_pkg::OP_PRUNE)
        begin
            for (int i = 0; i < ptla_pkg::ENTRIES; i++)
                if (slot_valid[i] && (t - slot_seen[i]) > age_limit)
                begin
                    hits.push_back(i);
                    gone.push_back(slot_addr[i]);
                    slot_valid[i] = 1'b0;
                    slot_addr[i] = '0;
                    slot_seen[i] = '0;
                end
            if (hits.size() == 0)
                push_result(ptla_pkg::ST_NONE_RM, 0, '0, 1'b1);
            else
                foreach (hits[k])
                    push_result(ptla_pkg::ST_REMOVED, hits[k], gone[k], k == hits.size() - 1);
        end
        // unused op: dropped, nothing queued
    endfunction

    // Receiver: randomly stall, compare every accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        peer_res_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat, status %0d", status);
                    fail_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, status);
                        fail_count++;
                    end
                    if (entry_index !== e.entry_index)
                    begin
                        $error("entry_index exp %0d got %0d", e.entry_index, entry_index);
                        fail_count++;
                    end
                    if (removed_address !== e.removed_address)
                    begin
                        $error("removed_address exp %h got %h", e.removed_address,
                               removed_address);
                        fail_count++;
                    end
                    if (active_count !== e.active_count)
                    begin
                        $error("active_count exp %0d got %0d", e.active_count, active_count);
                        fail_count++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, last);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold one beat on the input channel until accepted; predict at acceptance.
    // Valid stays high into the next beat when no idle cycle follows.
    task automatic send_beat(logic [1:0] o, logic [47:0] a, logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        peer_address <= a;
        now_ms <= t;
        do
            @(posedge clk);
        while (!in_ready);
        apply_command(o, a, t);
    endtask

    // Write a register with the block idle: drop valid, drain, then settle.
    task automatic write_reg(logic [ptla_pkg::CFG_IDX_W-1:0] idx, logic [47:0] d);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * ptla_pkg::ENTRIES + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ptla_pkg::REG_SELF_ADDRESS)
            own_addr = d;
        else
            age_limit = d[31:0];
    endtask

    function automatic logic [47:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Directed rows: reset checks, extremes, full table, self, op 3, prune.
    row_t dir_rows[$];
    function automatic row_t mk(logic [1:0] o, logic [47:0] a, logic [31:0] t,
                                bit ty = 0, logic [2:0] s = 0, logic [3:0] i = 0,
                                logic [4:0] c = 0);
        row_t r;
        r.op = o; r.addr = a; r.now = t; r.typed = ty; r.st = s; r.idx = i; r.cnt = c;
        return r;
    endfunction

    initial
    begin
        #5_000_000;
        $display("peer_table_learn_and_age: mismatch");
        $finish;
    end

    initial
    begin
        logic [1:0]  o;
        logic [47:0] a;
        logic [31:0] t;
        logic [31:0] clock_ms;
        int          r;
        row_t        row;
        peer_res_t   e;

        for (int i = 0; i < ptla_pkg::ENTRIES; i++)
        begin
            slot_valid[i] = 0;
            slot_addr[i] = '0;
            slot_seen[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(mk(ptla_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 1,
                              ptla_pkg::ST_NOT_FOUND, 0, 0));
        dir_rows.push_back(mk(ptla_pkg::OP_PRUNE, 0, 32'hFFFF_FFFF, 1,
                              ptla_pkg::ST_NONE_RM, 0, 0));
        dir_rows.push_back(mk(ptla_pkg::OP_LEARN, 0, 5, 1, ptla_pkg::ST_SELF, 0, 0));
        dir_rows.push_back(mk(ptla_pkg::OP_LEARN, 48'hFFFF_FFFF_FFFF, 0, 1,
                              ptla_pkg::ST_NEW, 0, 1));
        // refresh of a slot stamped at zero still reports new
        dir_rows.push_back(mk(ptla_pkg::OP_LEARN, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1,
                              ptla_pkg::ST_NEW, 0, 1));
        dir_rows.push_back(mk(ptla_pkg::OP_LEARN, 48'hFFFF_FFFF_FFFF, 100, 1,
                              ptla_pkg::ST_REFRESHED, 0, 1));
        dir_rows.push_back(mk(ptla_pkg::OP_NONE, 48'h1234, 7));
        dir_rows.push_back(mk(ptla_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 1,
                              ptla_pkg::ST_FOUND, 0, 1));
        for (int i = 1; i < ptla_pkg::ENTRIES; i++)
            dir_rows.push_back(mk(ptla_pkg::OP_LEARN, 48'h1000 + i, 200 + i, 1,
                                  ptla_pkg::ST_NEW, 4'(i), 5'(i + 1)));
        dir_rows.push_back(mk(ptla_pkg::OP_LEARN, 48'hABCD, 9, 1, ptla_pkg::ST_FULL, 0,
                              5'(ptla_pkg::ENTRIES)));
        // age check: the early stamps exceed the timeout, slot 0 (100) too
        dir_rows.push_back(mk(ptla_pkg::OP_PRUNE, 0, 30000 + 203));
        dir_rows.push_back(mk(ptla_pkg::OP_PRUNE, 0, 32'hFFFF_FFFF));

        send_idle_pct = 30;
        recv_idle_pct = 58;
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            send_beat(row.op, row.addr, row.now);
            if (row.typed)
            begin
                e = pending_results[$];
                if (e.status != row.st || e.entry_index != row.idx || e.active_count != row.cnt)
                begin
                    $error("directed row %0d: table expects status %0d idx %0d count %0d",
                           k, row.st, row.idx, row.cnt);
                    fail_count++;
                end
            end
        end

        // Random phases: settings change between them, idling swaps, then none.
        clock_ms = 32'hFFFF_F000;
        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:
                begin
                    write_reg(ptla_pkg::REG_SELF_ADDRESS, 48'hFFFF_FFFF_FFFF);
                    write_reg(ptla_pkg::REG_TIMEOUT_MS, 0);
                end
                1:
                begin
                    write_reg(ptla_pkg::REG_SELF_ADDRESS, rand_addr());
                    write_reg(ptla_pkg::REG_TIMEOUT_MS, 48'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(ptla_pkg::REG_SELF_ADDRESS, 0);
                    write_reg(ptla_pkg::REG_TIMEOUT_MS, 400);
                end
                default:
                begin
                    write_reg(ptla_pkg::REG_TIMEOUT_MS, 48'($urandom_range(50, 3000)));
                end
            endcase
            send_idle_pct = (ph == 1) ? 58 : (ph >= 2) ? 0 : 30;
            recv_idle_pct = (ph == 1) ? 30 : (ph >= 2) ? 0 : 58;
            for (int n = 0; n < 26; n++)
            begin
                clock_ms += $urandom_range(0, 300);
                r = $urandom_range(99);
                if (r < 45)
                    o = ptla_pkg::OP_LEARN;
                else if (r < 75)
                    o = ptla_pkg::OP_LOOKUP;
                else if (r < 95)
                    o = ptla_pkg::OP_PRUNE;
                else
                    o = ptla_pkg::OP_NONE;
                r = $urandom_range(99);
                if (r < 60 && known_peers.size() > 0)
                    a = known_peers[$urandom_range(known_peers.size() - 1)];
                else if (r < 65)
                    a = own_addr;
                else
                begin
                    a = rand_addr();
                    if (known_peers.size() < 24)
                        known_peers.push_back(a);
                end
                t = ($urandom_range(19) == 0) ? 32'($urandom) : clock_ms;
                send_beat(o, a, t);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * ptla_pkg::ENTRIES + 8) @(posedge clk);
        if (fail_count == 0)
            $display("peer_table_learn_and_age: match");
        else
            $display("peer_table_learn_and_age: mismatch");
        $finish;
    end
endmodule
